FILE: hdl/sql_statement_splitter_assert.svh
// Assertion macros for the SQL statement splitter.
`ifndef SQL_STATEMENT_SPLITTER_ASSERT_SVH
`define SQL_STATEMENT_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS

`define SSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sql_statement_splitter: same-cycle check failed");

`define SSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sql_statement_splitter: next-cycle check failed");

`else

`define SSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/sss_pkg.sv
// Shared constants, types and helpers for the SQL statement splitter.
package sss_pkg;

  localparam int WS_HOLD_DEPTH_DEF = 32;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_WS    = 2'd1;
  localparam kind_t KIND_CHAR  = 2'd2;
  localparam kind_t KIND_CLOSE = 2'd3;

  typedef struct packed {
    logic load;
    logic proc;
    logic sel_cur;
    logic gen_ws;
    logic gen_char;
    logic gen_end;
    logic clear_all;
    logic fin;
  } sss_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  ws_empty;
    logic  fl_last;
    logic  gen_rdy;
    logic  fin_done;
  } sss_sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

FILE: hdl/sql_statement_splitter.sv
// Top level: strips SQL comments, trims whitespace and splits statements on semicolons.
// Sequential: one input beat in flight; each beat is accepted, processed and finished,
// with a flush step per held whitespace byte and an emit step per kept byte and
// semicolon, and an in_tlast beat adds a lookahead and a close step; at most WS_HOLD_DEPTH + 3 results per beat.
// Results leave through a one-deep staging register and an output register.
// Reset (rst_n low, synchronous) clears all lexer, statement and handshake state.
`include "sql_statement_splitter_assert.svh"

module sql_statement_splitter #(
  parameter int WS_HOLD_DEPTH = sss_pkg::WS_HOLD_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_script
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] byte_valid, [1] statement_end, [2] ws_overflow
  output logic       out_tlast   // run_last
);
  import sss_pkg::*;

  sss_cmd_t cmd;
  sss_sts_t sts;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sss_datapath #(
    .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `SSS_ASSERT_NXT(a_one_beat_inflight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `SSS_ASSERT_IMP(a_byte_or_end, clk, rst_n, out_tvalid, out_tuser[0] != out_tuser[1])
  `SSS_ASSERT_IMP(a_end_zero_byte, clk, rst_n, out_tvalid && out_tuser[1], out_tdata == 8'd0)
  `SSS_ASSERT_IMP(a_no_accept_on_out, clk, rst_n, in_tready, sts.fin_done)

endmodule

FILE: hdl/sss_datapath.sv
// Datapath: lexer state, whitespace hold memory, result staging and output register.
module sss_datapath #(
  parameter int WS_HOLD_DEPTH = sss_pkg::WS_HOLD_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_tdata,
  input  sss_pkg::sss_cmd_t cmd,
  output sss_pkg::sss_sts_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);
  import sss_pkg::*;

  localparam int CW = $clog2(WS_HOLD_DEPTH + 1);
  localparam int AW = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(WS_HOLD_DEPTH);

  logic [7:0]    cur_r;
  logic [7:0]    held_byte_r;
  logic          held_valid_r;
  logic          skip_r;
  logic          sq_r, dq_r, lc_r, bc_r;
  logic          has_r;
  logic [CW-1:0] ws_count_r;
  logic          drop_r;
  logic [7:0]    char_r;
  logic [CW-1:0] fl_idx_r, fl_idx_nxt;
  logic [7:0]    rd_data_r;
  logic [7:0]    ws_hold [WS_HOLD_DEPTH];

  logic          pend_v_r, pend_bv_r, pend_end_r, pend_ovf_r;
  logic [7:0]    pend_byte_r;
  logic          out_v_r, out_last_r;
  logic [7:0]    out_byte_r;
  logic [2:0]    out_user_r;

  logic [7:0]    x;
  logic          has_n, run, norm, pair;
  logic          sq_n, dq_n, lc_n, bc_n;
  kind_t         kind;
  logic          out_free, gen_rdy, gen_fire, push_mid, push_fin;
  logic [7:0]    new_byte;

  always_comb begin
    x     = cmd.sel_cur ? cur_r : held_byte_r;
    has_n = !cmd.sel_cur;
    run   = (cmd.sel_cur || held_valid_r) && !skip_r;
    sq_n  = sq_r;
    dq_n  = dq_r;
    lc_n  = lc_r;
    bc_n  = bc_r;
    pair  = 1'b0;
    norm  = 1'b0;
    kind  = KIND_NONE;
    if (run) begin
      if (!sq_r && !dq_r) begin
        if (!lc_r && !bc_r && has_n && x == CH_DASH && cur_r == CH_DASH) begin
          lc_n = 1'b1;
          pair = 1'b1;
        end else if (!lc_r && !bc_r && has_n && x == CH_SLASH && cur_r == CH_STAR) begin
          bc_n = 1'b1;
          pair = 1'b1;
        end else if (bc_r && has_n && x == CH_STAR && cur_r == CH_SLASH) begin
          bc_n = 1'b0;
          pair = 1'b1;
        end else if (lc_r && (x == CH_LF || x == CH_CR)) begin
          lc_n = 1'b0;
        end else if (!lc_r && !bc_r) begin
          norm = 1'b1;
        end
      end else begin
        norm = 1'b1;
      end
      if (norm) begin
        if (x == CH_SQUOTE && !dq_r) begin
          sq_n = !sq_r;
        end else if (x == CH_DQUOTE && !sq_r) begin
          dq_n = !dq_r;
        end
        if (x == CH_SEMI && !sq_n && !dq_n) begin
          kind = KIND_CLOSE;
        end else if (is_ws(x)) begin
          kind = KIND_WS;
        end else begin
          kind = KIND_CHAR;
        end
      end
    end
  end

  assign out_free = !out_v_r || out_tready;
  assign gen_rdy  = !pend_v_r || out_free;
  assign gen_fire = gen_rdy && (cmd.gen_ws || cmd.gen_char || (cmd.gen_end && has_r));
  assign push_mid = gen_fire && pend_v_r;
  assign push_fin = cmd.fin && pend_v_r && out_free;
  assign new_byte = cmd.gen_ws ? rd_data_r : (cmd.gen_char ? char_r : 8'd0);

  always_comb begin
    if (cmd.proc) begin
      fl_idx_nxt = '0;
    end else if (cmd.gen_ws && gen_rdy) begin
      fl_idx_nxt = CW'(fl_idx_r + 1'b1);
    end else begin
      fl_idx_nxt = fl_idx_r;
    end
  end

  assign sts.kind     = kind;
  assign sts.ws_empty = (ws_count_r == '0);
  assign sts.fl_last  = (CW'(fl_idx_r + 1'b1) == ws_count_r);
  assign sts.gen_rdy  = gen_rdy;
  assign sts.fin_done = !pend_v_r || out_free;

  // hold memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.proc && kind == KIND_WS && has_r && ws_count_r < DEPTH_C) begin
      ws_hold[ws_count_r[AW-1:0]] <= x;
    end
    rd_data_r <= ws_hold[fl_idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= in_tdata;
    end
    if (cmd.proc) begin
      char_r <= x;
    end
    if (gen_fire) begin
      pend_byte_r <= new_byte;
      pend_bv_r   <= cmd.gen_ws || cmd.gen_char;
      pend_end_r  <= cmd.gen_end;
      pend_ovf_r  <= drop_r;
    end
    if (push_mid || push_fin) begin
      out_byte_r <= pend_byte_r;
      out_user_r <= {pend_ovf_r, pend_end_r, pend_bv_r};
      out_last_r <= push_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      skip_r       <= 1'b0;
      sq_r         <= 1'b0;
      dq_r         <= 1'b0;
      lc_r         <= 1'b0;
      bc_r         <= 1'b0;
      has_r        <= 1'b0;
      ws_count_r   <= '0;
      drop_r       <= 1'b0;
      fl_idx_r     <= '0;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      fl_idx_r <= fl_idx_nxt;
      if (cmd.proc) begin
        sq_r   <= sq_n;
        dq_r   <= dq_n;
        lc_r   <= lc_n;
        bc_r   <= bc_n;
        skip_r <= pair;
        if (!cmd.sel_cur) begin
          held_byte_r  <= cur_r;
          held_valid_r <= 1'b1;
        end
        if (kind == KIND_WS && has_r) begin
          if (ws_count_r < DEPTH_C) begin
            ws_count_r <= CW'(ws_count_r + 1'b1);
          end else begin
            drop_r <= 1'b1;
          end
        end
      end
      if (cmd.gen_char && gen_rdy) begin
        has_r      <= 1'b1;
        ws_count_r <= '0;
      end
      if (cmd.gen_end && gen_rdy) begin
        has_r      <= 1'b0;
        ws_count_r <= '0;
        drop_r     <= 1'b0;
      end
      if (cmd.clear_all) begin
        held_byte_r  <= 8'd0;
        held_valid_r <= 1'b0;
        skip_r       <= 1'b0;
        sq_r         <= 1'b0;
        dq_r         <= 1'b0;
        lc_r         <= 1'b0;
        bc_r         <= 1'b0;
      end
      if (gen_fire) begin
        pend_v_r <= 1'b1;
      end else if (push_fin) begin
        pend_v_r <= 1'b0;
      end
      if (push_mid || push_fin) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/sss_ctrl.sv
// Controller: sequences lookahead processing, whitespace flush and statement close per beat.
module sss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  sss_pkg::sss_sts_t sts,
  output sss_pkg::sss_cmd_t cmd
);
  import sss_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PH    = 3'd1;
  localparam logic [2:0] S_PL    = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_CHAR  = 3'd4;
  localparam logic [2:0] S_ENDM  = 3'd5;
  localparam logic [2:0] S_CLOSE = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       phase_l_r, phase_l_nxt;
  logic [2:0] after_emit;

  assign after_emit = phase_l_r ? S_CLOSE : (last_r ? S_PL : S_FIN);

  always_comb begin
    state_nxt   = state_r;
    last_nxt    = last_r;
    phase_l_nxt = phase_l_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load    = 1'b1;
          last_nxt    = in_tlast;
          phase_l_nxt = 1'b0;
          state_nxt   = S_PH;
        end
      end
      S_PH: begin
        cmd.proc = 1'b1;
        case (sts.kind)
          KIND_CHAR:  state_nxt = sts.ws_empty ? S_CHAR : S_FLUSH;
          KIND_CLOSE: state_nxt = S_ENDM;
          default:    state_nxt = last_r ? S_PL : S_FIN;
        endcase
      end
      S_PL: begin
        cmd.proc    = 1'b1;
        cmd.sel_cur = 1'b1;
        phase_l_nxt = 1'b1;
        case (sts.kind)
          KIND_CHAR:  state_nxt = sts.ws_empty ? S_CHAR : S_FLUSH;
          KIND_CLOSE: state_nxt = S_ENDM;
          default:    state_nxt = S_CLOSE;
        endcase
      end
      S_FLUSH: begin
        cmd.gen_ws = 1'b1;
        if (sts.gen_rdy && sts.fl_last) begin
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        cmd.gen_char = 1'b1;
        if (sts.gen_rdy) begin
          state_nxt = after_emit;
        end
      end
      S_ENDM: begin
        cmd.gen_end = 1'b1;
        if (sts.gen_rdy) begin
          state_nxt = after_emit;
        end
      end
      S_CLOSE: begin
        cmd.gen_end   = 1'b1;
        cmd.clear_all = 1'b1;
        if (sts.gen_rdy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (sts.fin_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      last_r    <= 1'b0;
      phase_l_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      last_r    <= last_nxt;
      phase_l_r <= phase_l_nxt;
    end
  end

endmodule
